>>> rtl/bsa_pkg.sv
// Shared constants, types and helper functions for the bitmap slab allocator.
package bsa_pkg;

  localparam int CLS_W          = 3;
  localparam int MAX_CLASSES    = 8;
  localparam int WORD_W         = 64;
  localparam int WORD_SEL_W     = 2;
  localparam int BIT_SEL_W      = 6;
  localparam int OBJ_IDX_W      = 8;
  localparam int FRAME_W        = 20;
  localparam int ADDR_W         = 32;
  localparam int PAGE_OFF_W     = 12;
  localparam int PAGE_BYTES     = 4096;
  localparam int SIZE_W         = 13;
  localparam int CNT_W          = 15;
  localparam int PCNT_W         = 7;
  localparam int PER_PAGE_W     = 9;
  localparam int MIN_OBJ_SHIFT  = 4;

  localparam int NUM_CLASSES_DEF         = 8;
  localparam int PAGES_PER_CLASS_DEF     = 64;
  localparam int RESERVED_FRAME_BASE_DEF = 256;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_FREE  = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_FAIL    = 2'd1;
  localparam status_t ST_IGNORED = 2'd2;

  typedef struct packed {
    logic             ok;
    logic [CLS_W-1:0] cls;
  } class_sel_t;

  // Smallest class whose object size covers the request.
  function automatic class_sel_t class_for_size(input logic [SIZE_W-1:0] size,
                                                input int num_classes);
    class_sel_t sel;
    sel.ok  = 1'b0;
    sel.cls = '0;
    for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
      if (c < num_classes && {1'b0, size} <= (14'd16 << c)) begin
        sel.ok  = 1'b1;
        sel.cls = CLS_W'(c);
      end
    end
    return sel;
  endfunction

  function automatic logic [PER_PAGE_W-1:0] objs_per_page(input logic [CLS_W-1:0] cls);
    return PER_PAGE_W'(9'd256 >> cls);
  endfunction

  // Index of the last bitmap word a page of this class uses.
  function automatic logic [WORD_SEL_W-1:0] last_word(input logic [CLS_W-1:0] cls);
    logic [WORD_SEL_W-1:0] w;
    case (cls)
      3'd0:    w = 2'd3;
      3'd1:    w = 2'd1;
      default: w = 2'd0;
    endcase
    return w;
  endfunction

  // Bits past the end of a page with fewer than 64 objects (class 3 and up) read as taken.
  function automatic logic [WORD_W-1:0] fill_mask(input logic [CLS_W-1:0] cls);
    logic [WORD_W-1:0] m;
    if (cls < 3'd3) begin
      m = '0;
    end else begin
      m = ~((64'd1 << objs_per_page(cls)) - 64'd1);
    end
    return m;
  endfunction

endpackage

>>> rtl/bsa_if.sv
// Channel interfaces for requests and results.
interface bsa_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic [bsa_pkg::SIZE_W-1:0]       request_size;
  logic [bsa_pkg::ADDR_W-1:0]       object_address;
  logic [bsa_pkg::FRAME_W-1:0]      spare_frame;
  logic [bsa_pkg::CLS_W-1:0]        class_index;

  modport source (output valid, command, request_size, object_address, spare_frame,
                  class_index, input ready);
  modport sink (input valid, command, request_size, object_address, spare_frame,
                class_index, output ready);
endinterface

interface bsa_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [bsa_pkg::ADDR_W-1:0]       result_address;
  logic                             frame_taken;
  logic                             frame_released;
  logic [bsa_pkg::FRAME_W-1:0]      released_frame;
  logic [bsa_pkg::CNT_W-1:0]        used_objects;
  logic [bsa_pkg::CNT_W-1:0]        free_objects;
  logic [bsa_pkg::PCNT_W-1:0]       present_pages;

  modport source (output valid, status, result_address, frame_taken, frame_released,
                  released_frame, used_objects, free_objects, present_pages, input ready);
  modport sink (input valid, status, result_address, frame_taken, frame_released,
                released_frame, used_objects, free_objects, present_pages, output ready);
endinterface

>>> rtl/bsa_ffz.sv
// Registered find-first-zero over one bitmap word.
module bsa_ffz (
  input  logic                              clk,
  input  logic [bsa_pkg::WORD_W-1:0]        word,
  output logic                              found_r,
  output logic [bsa_pkg::BIT_SEL_W-1:0]     pos_r
);

  logic                          found;
  logic [bsa_pkg::BIT_SEL_W-1:0] pos;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = bsa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        pos   = bsa_pkg::BIT_SEL_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found;
    pos_r   <= pos;
  end

endmodule

>>> rtl/bitmap_slab_allocator.sv
// Top level: sequencer, bitmap and slot memories, per-class counters.
// Alloc scans each page slot and the bitmap words of each present page, then installs
// a new page in the first absent slot if none has room; free finds the page by frame,
// clears the bit and may release the page. One request at a time; one bitmap memory.
// Reset: synchronous; a clearing pass over all 8*slots*4 bitmap words zeros
// the bitmaps and sets up slot 0 of each class before the first request is taken.
module bitmap_slab_allocator #(
  parameter int NUM_CLASSES         = bsa_pkg::NUM_CLASSES_DEF,
  parameter int PAGES_PER_CLASS     = bsa_pkg::PAGES_PER_CLASS_DEF,
  parameter int RESERVED_FRAME_BASE = bsa_pkg::RESERVED_FRAME_BASE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bsa_in_if.sink       in_if,
  bsa_out_if.source    out_if
);

  localparam int PW       = (PAGES_PER_CLASS > 1) ? $clog2(PAGES_PER_CLASS) : 1;
  localparam int PCW      = $clog2(PAGES_PER_CLASS + 1);
  localparam int CI_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SL_AW    = bsa_pkg::CLS_W + PW;
  localparam int BM_AW    = SL_AW + bsa_pkg::WORD_SEL_W;
  localparam int SL_DEPTH = 1 << SL_AW;
  localparam int BM_DEPTH = 1 << BM_AW;
  localparam int SL_W     = bsa_pkg::FRAME_W + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_A_SLOT_RD, S_A_SLOT_CHK, S_A_WORD_RD, S_A_WORD_CHK, S_A_FIND, S_A_END,
    S_A_NEW, S_A_NEW_W,
    S_F_SLOT_RD, S_F_SLOT_CHK, S_F_WORD_RD, S_F_WORD_CHK, S_F_CLR,
    S_F_EMPTY_RD, S_F_EMPTY_CHK, S_F_RELEASE,
    S_RESP
  } state_t;

  state_t state_r;

  logic [bsa_pkg::WORD_W-1:0] bits_mem [BM_DEPTH];
  logic [SL_W-1:0]            slot_mem [SL_DEPTH];

  logic [BM_AW-1:0]               clr_r;
  logic                           cls_ok_r;
  logic [bsa_pkg::CLS_W-1:0]      cls_r;
  logic [bsa_pkg::ADDR_W-1:0]     addr_r;
  logic [bsa_pkg::FRAME_W-1:0]    spare_r;
  logic [PCW-1:0]                 page_r;
  logic [bsa_pkg::WORD_SEL_W-1:0] word_r;
  logic                           absent_found_r;
  logic [PW-1:0]                  absent_r;
  logic [bsa_pkg::FRAME_W-1:0]    frame_r;
  logic [bsa_pkg::WORD_W-1:0]     word_data_r;
  logic [bsa_pkg::OBJ_IDX_W-1:0]  k_r;
  logic [bsa_pkg::WORD_W-1:0]     bm_rd_r;
  logic [SL_W-1:0]                sl_rd_r;

  bsa_pkg::status_t               status_r;
  logic [bsa_pkg::ADDR_W-1:0]     raddr_r;
  logic                           taken_r;
  logic                           released_r;
  logic [bsa_pkg::FRAME_W-1:0]    rframe_r;

  logic [bsa_pkg::CNT_W-1:0]      used_r [NUM_CLASSES];
  logic [bsa_pkg::CNT_W-1:0]      free_r [NUM_CLASSES];
  logic [bsa_pkg::PCNT_W-1:0]     pages_r [NUM_CLASSES];

  logic                           out_valid_r;
  logic [1:0]                     out_status_r;
  logic [bsa_pkg::ADDR_W-1:0]     out_addr_r;
  logic                           out_taken_r;
  logic                           out_released_r;
  logic [bsa_pkg::FRAME_W-1:0]    out_rframe_r;
  logic [bsa_pkg::CNT_W-1:0]      out_used_r;
  logic [bsa_pkg::CNT_W-1:0]      out_free_r;
  logic [bsa_pkg::PCNT_W-1:0]     out_pages_r;

  logic                           ffz_found_r;
  logic [bsa_pkg::BIT_SEL_W-1:0]  ffz_pos_r;

  logic [BM_AW-1:0]               bm_raddr;
  logic [SL_AW-1:0]               sl_raddr;
  logic                           bm_we;
  logic [BM_AW-1:0]               bm_waddr;
  logic [bsa_pkg::WORD_W-1:0]     bm_wdata;
  logic                           sl_we;
  logic [SL_AW-1:0]               sl_waddr;
  logic [SL_W-1:0]                sl_wdata;

  logic [CI_W-1:0]                cix;
  logic [PW-1:0]                  pix;
  logic [3:0]                     obj_sh;
  logic                           last_page;
  logic [bsa_pkg::WORD_SEL_W-1:0] last_w;
  logic [bsa_pkg::PAGE_OFF_W-1:0] alloc_off;
  logic [bsa_pkg::OBJ_IDX_W-1:0]  free_k;
  logic [bsa_pkg::PER_PAGE_W-1:0] n_obj;
  bsa_pkg::class_sel_t            in_sel;
  logic                           resp_go;
  logic [bsa_pkg::CLS_W-1:0]      clr_cls;
  logic [PW-1:0]                  clr_page;

  assign cix       = cls_r[CI_W-1:0];
  assign pix       = page_r[PW-1:0];
  assign obj_sh    = 4'(bsa_pkg::MIN_OBJ_SHIFT) + {1'b0, cls_r};
  assign last_page = (page_r == PCW'(PAGES_PER_CLASS - 1));
  assign last_w    = bsa_pkg::last_word(cls_r);
  assign n_obj     = bsa_pkg::objs_per_page(cls_r);
  assign alloc_off = bsa_pkg::PAGE_OFF_W'({word_r, ffz_pos_r}) << obj_sh;
  assign free_k    = bsa_pkg::OBJ_IDX_W'(addr_r[bsa_pkg::PAGE_OFF_W-1:0] >> obj_sh);
  assign in_sel    = bsa_pkg::class_for_size(in_if.request_size, NUM_CLASSES);
  assign resp_go   = !out_valid_r || out_if.ready;
  assign clr_cls   = clr_r[BM_AW-1 -: bsa_pkg::CLS_W];
  assign clr_page  = clr_r[bsa_pkg::WORD_SEL_W +: PW];

  assign bm_raddr = {cls_r, pix, word_r};
  assign sl_raddr = {cls_r, pix};

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = {cls_r, pix, word_r};
    bm_wdata = '0;
    sl_we    = 1'b0;
    sl_waddr = {cls_r, pix};
    sl_wdata = {1'b0, frame_r};
    case (state_r)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        // one slot per page; write it on the page's first word
        sl_we    = (clr_r[bsa_pkg::WORD_SEL_W-1:0] == '0);
        sl_waddr = {clr_cls, clr_page};
        sl_wdata = {(clr_page == '0) && ({1'b0, clr_cls} < 4'(NUM_CLASSES)),
                    bsa_pkg::FRAME_W'(RESERVED_FRAME_BASE) + bsa_pkg::FRAME_W'(clr_cls)};
      end
      S_A_FIND: begin
        bm_we    = ffz_found_r;
        bm_wdata = word_data_r | (64'd1 << ffz_pos_r);
      end
      S_A_NEW: begin
        sl_we    = 1'b1;
        sl_waddr = {cls_r, absent_r};
        sl_wdata = {1'b1, spare_r};
      end
      S_A_NEW_W: begin
        bm_we    = 1'b1;
        bm_waddr = {cls_r, absent_r, word_r};
        bm_wdata = (word_r == '0) ? 64'd1 : '0;
      end
      S_F_CLR: begin
        bm_we    = 1'b1;
        bm_wdata = word_data_r & ~(64'd1 << k_r[bsa_pkg::BIT_SEL_W-1:0]);
      end
      S_F_RELEASE: begin
        sl_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bm_we) bits_mem[bm_waddr] <= bm_wdata;
    if (sl_we) slot_mem[sl_waddr] <= sl_wdata;
    bm_rd_r <= bits_mem[bm_raddr];
    sl_rd_r <= slot_mem[sl_raddr];
  end

  bsa_ffz u_ffz (
    .clk     (clk),
    .word    (bm_rd_r | bsa_pkg::fill_mask(cls_r)),
    .found_r (ffz_found_r),
    .pos_r   (ffz_pos_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        used_r[c]  <= '0;
        free_r[c]  <= bsa_pkg::CNT_W'(bsa_pkg::objs_per_page(bsa_pkg::CLS_W'(c)));
        pages_r[c] <= bsa_pkg::PCNT_W'(1);
      end
    end else begin
      if (out_valid_r && out_if.ready && state_r != S_RESP) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BM_AW'(BM_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_if.valid) begin
            addr_r         <= in_if.object_address;
            spare_r        <= in_if.spare_frame;
            page_r         <= '0;
            word_r         <= '0;
            absent_found_r <= 1'b0;
            raddr_r        <= '0;
            taken_r        <= 1'b0;
            released_r     <= 1'b0;
            rframe_r       <= '0;
            status_r       <= bsa_pkg::ST_DONE;
            case (in_if.command)
              bsa_pkg::CMD_ALLOC: begin
                cls_r    <= in_sel.cls;
                cls_ok_r <= in_sel.ok;
                if (in_sel.ok) begin
                  state_r <= S_A_SLOT_RD;
                end else begin
                  status_r <= bsa_pkg::ST_FAIL;
                  state_r  <= S_RESP;
                end
              end
              bsa_pkg::CMD_FREE: begin
                cls_r    <= in_sel.cls;
                cls_ok_r <= in_sel.ok;
                status_r <= bsa_pkg::ST_IGNORED;
                if (in_sel.ok && in_if.request_size != '0 && in_if.object_address != '0)
                  state_r <= S_F_SLOT_RD;
                else
                  state_r <= S_RESP;
              end
              default: begin
                cls_r    <= in_if.class_index;
                cls_ok_r <= ({1'b0, in_if.class_index} < 4'(NUM_CLASSES));
                state_r  <= S_RESP;
              end
            endcase
          end
        end
        S_A_SLOT_RD: state_r <= S_A_SLOT_CHK;
        S_A_SLOT_CHK: begin
          if (sl_rd_r[SL_W-1]) begin
            frame_r <= sl_rd_r[bsa_pkg::FRAME_W-1:0];
            word_r  <= '0;
            state_r <= S_A_WORD_RD;
          end else begin
            if (!absent_found_r) begin
              absent_found_r <= 1'b1;
              absent_r       <= pix;
            end
            if (last_page) begin
              state_r <= S_A_END;
            end else begin
              page_r  <= page_r + 1'b1;
              state_r <= S_A_SLOT_RD;
            end
          end
        end
        S_A_WORD_RD: state_r <= S_A_WORD_CHK;
        S_A_WORD_CHK: begin
          word_data_r <= bm_rd_r;
          state_r     <= S_A_FIND;
        end
        S_A_FIND: begin
          if (ffz_found_r) begin
            raddr_r      <= {frame_r, alloc_off};
            used_r[cix]  <= used_r[cix] + 1'b1;
            free_r[cix]  <= free_r[cix] - 1'b1;
            state_r      <= S_RESP;
          end else if (word_r != last_w) begin
            word_r  <= word_r + 1'b1;
            state_r <= S_A_WORD_RD;
          end else if (last_page) begin
            state_r <= S_A_END;
          end else begin
            page_r  <= page_r + 1'b1;
            state_r <= S_A_SLOT_RD;
          end
        end
        S_A_END: begin
          if (absent_found_r) begin
            state_r <= S_A_NEW;
          end else begin
            status_r <= bsa_pkg::ST_FAIL;
            state_r  <= S_RESP;
          end
        end
        S_A_NEW: begin
          word_r  <= '0;
          state_r <= S_A_NEW_W;
        end
        S_A_NEW_W: begin
          word_r <= word_r + 1'b1;
          if (word_r == '1) begin
            raddr_r      <= {spare_r, bsa_pkg::PAGE_OFF_W'(0)};
            taken_r      <= 1'b1;
            used_r[cix]  <= used_r[cix] + 1'b1;
            free_r[cix]  <= free_r[cix] + bsa_pkg::CNT_W'(n_obj) - 1'b1;
            pages_r[cix] <= pages_r[cix] + 1'b1;
            state_r      <= S_RESP;
          end
        end
        S_F_SLOT_RD: state_r <= S_F_SLOT_CHK;
        S_F_SLOT_CHK: begin
          if (sl_rd_r[SL_W-1] &&
              sl_rd_r[bsa_pkg::FRAME_W-1:0] == addr_r[bsa_pkg::ADDR_W-1 -: bsa_pkg::FRAME_W]) begin
            frame_r <= sl_rd_r[bsa_pkg::FRAME_W-1:0];
            k_r     <= free_k;
            word_r  <= free_k[bsa_pkg::OBJ_IDX_W-1 -: bsa_pkg::WORD_SEL_W];
            state_r <= S_F_WORD_RD;
          end else if (last_page) begin
            state_r <= S_RESP;
          end else begin
            page_r  <= page_r + 1'b1;
            state_r <= S_F_SLOT_RD;
          end
        end
        S_F_WORD_RD: state_r <= S_F_WORD_CHK;
        S_F_WORD_CHK: begin
          word_data_r <= bm_rd_r;
          if (bm_rd_r[k_r[bsa_pkg::BIT_SEL_W-1:0]]) begin
            status_r <= bsa_pkg::ST_DONE;
            state_r  <= S_F_CLR;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_F_CLR: begin
          used_r[cix] <= used_r[cix] - 1'b1;
          free_r[cix] <= free_r[cix] + 1'b1;
          word_r      <= '0;
          state_r     <= S_F_EMPTY_RD;
        end
        S_F_EMPTY_RD: state_r <= S_F_EMPTY_CHK;
        S_F_EMPTY_CHK: begin
          if (bm_rd_r != '0) begin
            state_r <= S_RESP;
          end else if (word_r == last_w) begin
            state_r <= S_F_RELEASE;
          end else begin
            word_r  <= word_r + 1'b1;
            state_r <= S_F_EMPTY_RD;
          end
        end
        S_F_RELEASE: begin
          released_r   <= 1'b1;
          rframe_r     <= frame_r;
          pages_r[cix] <= pages_r[cix] - 1'b1;
          free_r[cix]  <= free_r[cix] - bsa_pkg::CNT_W'(n_obj);
          state_r      <= S_RESP;
        end
        S_RESP: begin
          if (resp_go) begin
            out_valid_r    <= 1'b1;
            out_status_r   <= status_r;
            out_addr_r     <= raddr_r;
            out_taken_r    <= taken_r;
            out_released_r <= released_r;
            out_rframe_r   <= rframe_r;
            out_used_r     <= cls_ok_r ? used_r[cix] : '0;
            out_free_r     <= cls_ok_r ? free_r[cix] : '0;
            out_pages_r    <= cls_ok_r ? pages_r[cix] : '0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready           = (state_r == S_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_status_r;
  assign out_if.result_address = out_addr_r;
  assign out_if.frame_taken    = out_taken_r;
  assign out_if.frame_released = out_released_r;
  assign out_if.released_frame = out_rframe_r;
  assign out_if.used_objects   = out_used_r;
  assign out_if.free_objects   = out_free_r;
  assign out_if.present_pages  = out_pages_r;

endmodule

>>> bench/bitmap_slab_allocator_chk.sv
// Checker for the slab allocator: watches both channels, predicts each result and compares.
module bitmap_slab_allocator_chk
  import bsa_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  bsa_in_if      in_if,
  bsa_out_if     out_if,
  output int     errors,
  output int     pending,
  output int     results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCLS  = NUM_CLASSES_DEF;
  localparam int NSLOT = PAGES_PER_CLASS_DEF;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   result_address;
    logic                frame_taken;
    logic                frame_released;
    logic [FRAME_W-1:0]  released_frame;
    logic [CNT_W-1:0]    used_objects;
    logic [CNT_W-1:0]    free_objects;
    logic [PCNT_W-1:0]   present_pages;
  } alloc_result_t;

  logic [255:0]       page_map [NCLS][NSLOT];
  logic [FRAME_W-1:0] page_frame [NCLS][NSLOT];
  logic               page_live [NCLS][NSLOT];
  int unsigned        used_cnt [NCLS];
  int unsigned        free_cnt [NCLS];
  int unsigned        page_cnt [NCLS];

  alloc_result_t expected_results[$];

  function automatic int size_class(input logic [SIZE_W-1:0] size);
    for (int c = 0; c < NCLS; c++)
      if (size <= (16 << c)) return c;
    return -1;
  endfunction

  task automatic reset_model();
    for (int c = 0; c < NCLS; c++) begin
      for (int p = 0; p < NSLOT; p++) begin
        page_map[c][p] = '0;
        page_frame[c][p] = '0;
        page_live[c][p] = 1'b0;
      end
      page_live[c][0] = 1'b1;
      page_frame[c][0] = FRAME_W'(RESERVED_FRAME_BASE_DEF + c);
      used_cnt[c] = 0;
      free_cnt[c] = 256 >> c;
      page_cnt[c] = 1;
    end
  endtask

  task automatic predict_request(input cmd_t cmd, input logic [SIZE_W-1:0] size,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic [FRAME_W-1:0] spare,
                                 input logic [CLS_W-1:0] qcls);
    alloc_result_t r;
    int c, n, hit;
    bit done;
    r = '0;
    done = 0;
    c = -1;
    if (cmd == CMD_ALLOC) begin
      c = size_class(size);
      if (c < 0) r.status = ST_FAIL;
      else begin
        n = 256 >> c;
        for (int p = 0; p < NSLOT && !done; p++) begin
          if (!page_live[c][p]) continue;
          for (int k = 0; k < n; k++)
            if (!page_map[c][p][k]) begin
              page_map[c][p][k] = 1'b1;
              used_cnt[c]++;
              free_cnt[c]--;
              r.result_address = page_frame[c][p] * PAGE_BYTES + k * (16 << c);
              done = 1;
              break;
            end
        end
        for (int p = 0; p < NSLOT && !done; p++) begin
          if (page_live[c][p]) continue;
          page_live[c][p] = 1'b1;
          page_frame[c][p] = spare;
          page_map[c][p] = 256'd1;
          used_cnt[c]++;
          free_cnt[c] += n - 1;
          page_cnt[c]++;
          r.result_address = spare * PAGE_BYTES;
          r.frame_taken = 1'b1;
          done = 1;
        end
        if (!done) r.status = ST_FAIL;
      end
    end else if (cmd == CMD_FREE) begin
      c = size_class(size);
      r.status = ST_IGNORED;
      if (c >= 0 && size != 0 && addr != 0) begin
        n = 256 >> c;
        hit = -1;
        for (int p = 0; p < NSLOT; p++)
          if (page_live[c][p] && addr[ADDR_W-1:PAGE_OFF_W] == page_frame[c][p]) begin
            hit = p;
            break;
          end
        if (hit >= 0) begin
          int k;
          k = addr[PAGE_OFF_W-1:0] / (16 << c);
          if (page_map[c][hit][k]) begin
            r.status = ST_DONE;
            page_map[c][hit][k] = 1'b0;
            free_cnt[c]++;
            used_cnt[c]--;
            if (page_map[c][hit] == '0) begin
              r.frame_released = 1'b1;
              r.released_frame = page_frame[c][hit];
              page_live[c][hit] = 1'b0;
              page_cnt[c]--;
              free_cnt[c] -= n;
            end
          end
        end
      end
    end else begin
      c = (qcls < NCLS) ? int'(qcls) : -1;
    end
    if (c >= 0) begin
      r.used_objects = CNT_W'(used_cnt[c]);
      r.free_objects = CNT_W'(free_cnt[c]);
      r.present_pages = PCNT_W'(page_cnt[c]);
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH t=%0t %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      expected_results.delete();
      errors = 0;
      results_seen <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        alloc_result_t e;
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) report_mismatch("unexpected result beat", 1, 0);
        else begin
          e = expected_results.pop_front();
          if (out_if.status !== e.status) report_mismatch("status", out_if.status, e.status);
          if (out_if.result_address !== e.result_address)
            report_mismatch("result_address", out_if.result_address, e.result_address);
          if (out_if.frame_taken !== e.frame_taken)
            report_mismatch("frame_taken", out_if.frame_taken, e.frame_taken);
          if (out_if.frame_released !== e.frame_released)
            report_mismatch("frame_released", out_if.frame_released, e.frame_released);
          if (out_if.released_frame !== e.released_frame)
            report_mismatch("released_frame", out_if.released_frame, e.released_frame);
          if (out_if.used_objects !== e.used_objects)
            report_mismatch("used_objects", out_if.used_objects, e.used_objects);
          if (out_if.free_objects !== e.free_objects)
            report_mismatch("free_objects", out_if.free_objects, e.free_objects);
          if (out_if.present_pages !== e.present_pages)
            report_mismatch("present_pages", out_if.present_pages, e.present_pages);
        end
      end
      // predict after popping so a same-edge result is never matched to this beat
      if (in_if.valid && in_if.ready)
        predict_request(in_if.command, in_if.request_size, in_if.object_address,
                        in_if.spare_frame, in_if.class_index);
    end
    pending = expected_results.size();
  end
endmodule

>>> bench/bitmap_slab_allocator_tb.sv
// Top of the slab allocator bench: clock, reset, stimulus, receiver stalls and verdict.
module bitmap_slab_allocator_tb;
  import bsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors, pending, results_seen;
  int   gap_left = 0;
  int   burst_left = 0;
  int   beats_sent = 0;

  // outstanding allocations per class, for well-formed frees
  logic [ADDR_W-1:0] live_addrs [8][$];
  logic [FRAME_W-1:0] next_frame = 20'h00400;

  bsa_in_if  in_if();
  bsa_out_if out_if();

  bitmap_slab_allocator uut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));
  bitmap_slab_allocator_chk chk (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
                                 .errors(errors), .pending(pending),
                                 .results_seen(results_seen));

  always #2 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.command = CMD_QUERY;
    in_if.request_size = '0;
    in_if.object_address = '0;
    in_if.spare_frame = '0;
    in_if.class_index = '0;
    out_if.ready = 1'b0;
  end

  // receiver: phases of steady accept, random stalls, and long stalls
  always @(posedge clk) begin
    case ((results_seen / 40) % 3)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      default: out_if.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic send_beat(input cmd_t cmd, input logic [SIZE_W-1:0] size,
                           input logic [ADDR_W-1:0] addr, input logic [FRAME_W-1:0] spare,
                           input logic [CLS_W-1:0] qcls);
    // valid drops after each accepted beat before the next one is driven
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
      repeat (gap_left) @(posedge clk);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.request_size <= size;
    in_if.object_address <= addr;
    in_if.spare_frame <= spare;
    in_if.class_index <= qcls;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    in_if.valid <= 1'b0;
    beats_sent++;
  endtask

  function automatic int size_class(input int size);
    for (int c = 0; c < 8; c++)
      if (size <= (16 << c)) return c;
    return -1;
  endfunction

  task automatic do_alloc(input int size);
    int c;
    int idx;
    c = size_class(size);
    idx = beats_sent;
    next_frame = next_frame + 20'd1;
    send_beat(CMD_ALLOC, SIZE_W'(size), $urandom, next_frame, CLS_W'($urandom));
    // address is the one the allocator hands out; take it from this beat's own result
    do @(posedge clk);
    while (!(out_if.valid && out_if.ready && results_seen == idx));
    if (c >= 0 && out_if.status == ST_DONE) live_addrs[c].push_back(out_if.result_address);
  endtask

  task automatic do_free(input int c);
    int i;
    logic [ADDR_W-1:0] a;
    if (live_addrs[c].size() == 0) return;
    i = $urandom_range(0, live_addrs[c].size() - 1);
    a = live_addrs[c][i];
    live_addrs[c].delete(i);
    // unaligned offsets inside the object still name it
    a = a + ($urandom % (16 << c));
    send_beat(CMD_FREE, SIZE_W'($urandom_range((c == 0) ? 1 : (8 << c) + 1, 16 << c)),
              a, FRAME_W'($urandom), CLS_W'($urandom));
  endtask

  initial begin
    int sz, c, op;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and special cases
    for (int q = 0; q < 8; q++) send_beat(CMD_QUERY, '0, '0, '0, CLS_W'(q));
    send_beat(cmd_t'(2'd3), 13'h1fff, 32'hffffffff, 20'hfffff, 3'd7);
    send_beat(CMD_ALLOC, 13'd4096, '0, '0, '0);
    send_beat(CMD_ALLOC, 13'h1fff, 32'hffffffff, 20'hfffff, 3'd7);
    send_beat(CMD_FREE, 13'd4096, 32'h00100000, '0, '0);
    do_alloc(0);
    do_alloc(16);
    do_alloc(2048);
    do_alloc(2048);
    do_alloc(17);
    send_beat(CMD_FREE, 13'd0, 32'h00100000, '0, '0);
    send_beat(CMD_FREE, 13'd16, 32'h0, '0, '0);
    send_beat(CMD_FREE, 13'd16, 32'hfffff000, '0, '0);
    send_beat(CMD_FREE, 13'd16, 32'h00100ff0, '0, '0);
    send_beat(CMD_FREE, 13'd2048, 32'h00107800, '0, '0);
    do_free(0);
    do_free(7);
    do_free(7);
    do_free(1);

    // fill class 7 to full (64 pages of 2 objects) then drain it
    for (int i = 0; i < 130; i++) do_alloc($urandom_range(1025, 2048));
    while (live_addrs[7].size() != 0) do_free(7);

    // random: mostly well-formed alloc/free with noise; big classes get more pages
    for (int i = 0; i < 1250; i++) begin
      op = $urandom_range(0, 99);
      if (op < 45) begin
        sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096)
                                          : (16 << $urandom_range(3, 7)) - $urandom_range(0, 7);
        do_alloc(sz);
      end else if (op < 85) begin
        c = $urandom_range(0, 7);
        if (live_addrs[c].size() == 0) c = $urandom_range(3, 7);
        do_free(c);
      end else if (op < 93) begin
        send_beat(CMD_FREE, SIZE_W'($urandom), $urandom, FRAME_W'($urandom),
                  CLS_W'($urandom));
      end else begin
        send_beat(cmd_t'($urandom_range(2, 3)), SIZE_W'($urandom), $urandom,
                  FRAME_W'($urandom), CLS_W'($urandom));
      end
    end
    for (int q = 0; q < 8; q++) send_beat(CMD_QUERY, '0, '0, '0, CLS_W'(q));

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d results: queries, oversized and malformed requests,", results_seen);
    $display("class fill to capacity, page installs and releases under random stalls.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
